// ----- hdl/ps2ct_pkg.sv -----
package ps2ct_pkg;

    // field widths fixed by the packet format and register map
    localparam int BYTE_BITS  = 8;
    localparam int LIMIT_BITS = 12;
    localparam int OUT_BITS   = 12;
    localparam int APB_DATA   = 32;
    localparam int APB_ADDR   = 3;

    // byte 0 flag bits
    localparam int SYNC_IDX = 3;
    localparam int LEFT_IDX = 0;

    // register reset values
    localparam logic [LIMIT_BITS-1:0] X_LIMIT_RST = 12'd799;
    localparam logic [LIMIT_BITS-1:0] Y_LIMIT_RST = 12'd599;

    // cursor start position before masking to the coordinate width
    localparam int POS_X_RST = 400;
    localparam int POS_Y_RST = 300;

    // register indexes (byte address 4*i)
    typedef enum logic
    {
        REG_X_LIMIT = 1'b0,
        REG_Y_LIMIT = 1'b1
    } reg_idx_t;

    // position within a packet
    typedef enum logic [1:0]
    {
        PH_HEAD = 2'd0,
        PH_DX   = 2'd1,
        PH_DY   = 2'd2
    } phase_t;

endpackage

// ----- hdl/ps2ct_if.sv -----
interface ps2ct_byte_if;
    logic                            valid;
    logic                            ready;
    logic                            from_mouse;
    logic [ps2ct_pkg::BYTE_BITS-1:0] rx_byte;

    modport source (output valid, output from_mouse, output rx_byte, input ready);
    modport sink   (input valid, input from_mouse, input rx_byte, output ready);
endinterface

interface ps2ct_cursor_if;
    logic                           valid;
    logic                           ready;
    logic [ps2ct_pkg::OUT_BITS-1:0] cursor_x;
    logic [ps2ct_pkg::OUT_BITS-1:0] cursor_y;
    logic                           left_down;

    modport source (output valid, output cursor_x, output cursor_y, output left_down,
                    input ready);
    modport sink   (input valid, input cursor_x, input cursor_y, input left_down,
                    output ready);
endinterface

// ----- hdl/ps2ct_axis.sv -----
module ps2ct_axis #(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0]            pos,
    input  logic [ps2ct_pkg::BYTE_BITS-1:0]  delta,
    input  logic                             negate,
    input  logic [ps2ct_pkg::LIMIT_BITS-1:0] limit,
    output logic [COORD_BITS-1:0]            new_pos,
    output logic [COORD_BITS-1:0]            lim_pos
);
    import ps2ct_pkg::*;

    localparam int W = COORD_BITS + 2;

    logic [15:0]  lim16;
    logic [W-1:0] pos_e;
    logic [W-1:0] delta_e;
    logic [W-1:0] lim_e;
    logic [W-1:0] sum;

    // limit masked to the coordinate width
    assign lim16   = 16'(limit);
    assign lim_pos = lim16[COORD_BITS-1:0];

    assign pos_e   = {2'b00, pos};
    assign delta_e = {{(W-BYTE_BITS){delta[BYTE_BITS-1]}}, delta};
    assign lim_e   = {2'b00, lim_pos};

    // two spare bits: no overflow, and -(-128) comes out as +128
    assign sum = negate ? (pos_e - delta_e) : (pos_e + delta_e);

    always_comb
    begin
        if (sum[W-1])
            new_pos = '0;
        else if (sum > lim_e)
            new_pos = lim_pos;
        else
            new_pos = sum[COORD_BITS-1:0];
    end

endmodule

// ----- hdl/ps2_mouse_packet_cursor_tracker.sv -----
// Channel     Dir  Fields                          Word
// in_byte     in   from_mouse, rx_byte             one received byte
// out_cursor  out  cursor_x, cursor_y, left_down   cursor after a full packet
// apb         in   x_limit @0x0, y_limit @0x4      limit registers
//
// One word per cycle sustained unless a stalled result blocks it. A byte is
// registered on acceptance and the packet step runs from that register; on
// a third byte the step loads the result register.
// rst_n clears the phase, valids, limits (799/599) and cursor (400,300).
// A stalled result holds the input register only once a third byte is
// waiting behind it; other bytes keep flowing.
module ps2_mouse_packet_cursor_tracker #(
    parameter int COORD_BITS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    ps2ct_byte_if.sink                       in_byte,
    ps2ct_cursor_if.source                   out_cursor,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ps2ct_pkg::APB_ADDR-1:0]   paddr,
    input  logic [ps2ct_pkg::APB_DATA-1:0]   pwdata,
    output logic [ps2ct_pkg::APB_DATA-1:0]   prdata,
    output logic                             pready
);
    import ps2ct_pkg::*;

    localparam logic [COORD_BITS-1:0] X_RST = COORD_BITS'(POS_X_RST);
    localparam logic [COORD_BITS-1:0] Y_RST = COORD_BITS'(POS_Y_RST);

    // limit registers
    logic [LIMIT_BITS-1:0] x_limit_reg;
    logic [LIMIT_BITS-1:0] y_limit_reg;
    reg_idx_t              cfg_idx;
    logic                  cfg_wr;

    // input register
    logic                  in_vld_reg;
    logic                  in_flag_reg;
    logic [BYTE_BITS-1:0]  in_byte_reg;

    // packet state
    phase_t                phase_reg;
    phase_t                phase_next;
    logic                  held_left_reg;
    logic [BYTE_BITS-1:0]  held_dx_reg;
    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_y_reg;

    // result register
    logic                  out_vld_reg;
    logic [OUT_BITS-1:0]   out_x_reg;
    logic [OUT_BITS-1:0]   out_y_reg;
    logic                  out_left_reg;

    logic                  emit;
    logic                  advance;
    logic [COORD_BITS-1:0] new_x;
    logic [COORD_BITS-1:0] new_y;
    logic [COORD_BITS-1:0] lim_x;
    logic [COORD_BITS-1:0] lim_y;
    logic [15:0]           new_x16;
    logic [15:0]           new_y16;

    // ---- APB ----
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= X_LIMIT_RST;
            y_limit_reg <= Y_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_X_LIMIT: x_limit_reg <= pwdata[LIMIT_BITS-1:0];
                REG_Y_LIMIT: y_limit_reg <= pwdata[LIMIT_BITS-1:0];
                default:     x_limit_reg <= x_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_X_LIMIT: prdata = APB_DATA'(x_limit_reg);
            REG_Y_LIMIT: prdata = APB_DATA'(y_limit_reg);
            default:     prdata = '0;
        endcase
    end

    // ---- packet step ----
    // only a mouse byte in the Y phase produces a result
    assign emit    = in_vld_reg && in_flag_reg && (phase_reg == PH_DY);
    // the held word retires unless its result has nowhere to go
    assign advance = in_vld_reg && (!emit || !out_vld_reg || out_cursor.ready);
    assign in_byte.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_byte.ready)
            in_vld_reg <= in_byte.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_byte.ready && in_byte.valid)
        begin
            in_flag_reg <= in_byte.from_mouse;
            in_byte_reg <= in_byte.rx_byte;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (in_vld_reg && in_flag_reg)
        begin
            case (phase_reg)
                PH_HEAD: phase_next = in_byte_reg[SYNC_IDX] ? PH_DX : PH_HEAD;
                PH_DX:   phase_next = PH_DY;
                PH_DY:   phase_next = PH_HEAD;
                default: phase_next = PH_HEAD;
            endcase
        end
    end

    ps2ct_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .pos     (pos_x_reg),
        .delta   (held_dx_reg),
        .negate  (1'b0),
        .limit   (x_limit_reg),
        .new_pos (new_x),
        .lim_pos (lim_x)
    );

    // screen Y grows downward, mouse Y grows upward
    ps2ct_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .pos     (pos_y_reg),
        .delta   (in_byte_reg),
        .negate  (1'b1),
        .limit   (y_limit_reg),
        .new_pos (new_y),
        .lim_pos (lim_y)
    );

    assign new_x16 = 16'(new_x);
    assign new_y16 = 16'(new_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEAD;
            held_left_reg <= 1'b0;
            held_dx_reg   <= '0;
            pos_x_reg     <= X_RST;
            pos_y_reg     <= Y_RST;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            if (in_flag_reg && phase_reg == PH_HEAD && in_byte_reg[SYNC_IDX])
                held_left_reg <= in_byte_reg[LEFT_IDX];
            if (in_flag_reg && phase_reg == PH_DX)
                held_dx_reg <= in_byte_reg;
            if (emit)
            begin
                pos_x_reg <= new_x;
                pos_y_reg <= new_y;
            end
        end
    end

    // ---- result register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance && emit)
            out_vld_reg <= 1'b1;
        else if (out_cursor.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_x_reg    <= new_x16[OUT_BITS-1:0];
            out_y_reg    <= new_y16[OUT_BITS-1:0];
            out_left_reg <= held_left_reg;
        end
    end

    assign out_cursor.valid     = out_vld_reg;
    assign out_cursor.cursor_x  = out_x_reg;
    assign out_cursor.cursor_y  = out_y_reg;
    assign out_cursor.left_down = out_left_reg;

`ifndef SYNTHESIS
    // a waiting byte is not lost or altered while the step is blocked
    a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !advance |=> in_vld_reg && $stable(in_byte_reg))
        else $error("held byte changed while blocked");

    // cursor never lands outside its limit after a move
    a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |=> pos_x_reg <= lim_x)
        else $error("cursor x above limit");

    a_y_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |=> pos_y_reg <= lim_y)
        else $error("cursor y above limit");

    // a result only leaves once taken
    a_out_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_vld_reg) |-> $past(out_cursor.ready))
        else $error("result dropped");
`endif

endmodule

// ----- dv/ps2_mouse_packet_cursor_tracker_tb.sv -----
module ps2_mouse_packet_cursor_tracker_tb;

    import ps2ct_pkg::*;

    // generous ceiling: ~1600 bytes, each with at most a long gap on both sides
    localparam int CYCLE_LIMIT = 1000000;

    // extra cycles after the last expected word, covering a byte still in flight
    localparam int DRAIN_CYCLES = 8;

    // long receiver hold-off, long enough to fill the block and stall its input
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int HOLD_OFF_AT     = 30;

    // cursor word as seen on the output channel
    typedef struct packed
    {
        logic [OUT_BITS-1:0] x;
        logic [OUT_BITS-1:0] y;
        logic                left;
    } cursor_t;

    // Packet assembler and cursor tracker, mirrored in the testbench.
    // take_byte() runs on every accepted input word, check_cursor() on every
    // accepted output word.
    class cursor_predictor;
        logic [LIMIT_BITS-1:0] x_lim;
        logic [LIMIT_BITS-1:0] y_lim;
        logic [OUT_BITS-1:0]   pos_x;
        logic [OUT_BITS-1:0]   pos_y;
        phase_t                phase;
        logic                  left;
        logic [BYTE_BITS-1:0]  dx;
        cursor_t               cursor_due[$];
        int                    errors;

        function new();
            x_lim  = X_LIMIT_RST;
            y_lim  = Y_LIMIT_RST;
            pos_x  = OUT_BITS'(POS_X_RST);
            pos_y  = OUT_BITS'(POS_Y_RST);
            phase  = PH_HEAD;
            left   = 1'b0;
            dx     = '0;
            errors = 0;
        endfunction

        function void set_limit(reg_idx_t idx, logic [LIMIT_BITS-1:0] val);
            if (idx == REG_X_LIMIT)
                x_lim = val;
            else
                y_lim = val;
        endfunction

        function logic [OUT_BITS-1:0] saturate(int v, logic [LIMIT_BITS-1:0] lim);
            if (v < 0)
                return '0;
            if (v > int'(lim))
                return OUT_BITS'(lim);
            return OUT_BITS'(v);
        endfunction

        function void take_byte(logic fm, logic [BYTE_BITS-1:0] b);
            int      sdx;
            int      sdy;
            cursor_t c;
            if (!fm)
                return;
            case (phase)
                PH_HEAD:
                begin
                    // header dropped unless the sync bit is set
                    if (b[SYNC_IDX])
                    begin
                        left  = b[LEFT_IDX];
                        phase = PH_DX;
                    end
                end
                PH_DX:
                begin
                    dx    = b;
                    phase = PH_DY;
                end
                default:
                begin
                    // y axis runs opposite to the mouse; -(-128) moves by +128
                    phase  = PH_HEAD;
                    sdx    = $signed(dx);
                    sdy    = $signed(b);
                    pos_x  = saturate(int'(pos_x) + sdx, x_lim);
                    pos_y  = saturate(int'(pos_y) - sdy, y_lim);
                    c.x    = pos_x;
                    c.y    = pos_y;
                    c.left = left;
                    cursor_due.push_back(c);
                end
            endcase
        endfunction

        function void compare(string what, int want, int got);
            if (want != got)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch %s: expected %0d, got %0d", what, want, got);
            end
        endfunction

        function void check_cursor(logic [OUT_BITS-1:0] x, logic [OUT_BITS-1:0] y,
                                   logic l);
            cursor_t c;
            if (cursor_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected cursor word: x %0d y %0d left %0d", x, y, l);
                return;
            end
            c = cursor_due.pop_front();
            compare("cursor_x", c.x, x);
            compare("cursor_y", c.y, y);
            compare("left_down", c.left, l);
        endfunction

        function int pending();
            return cursor_due.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR-1:0]   paddr;
    logic [APB_DATA-1:0]   pwdata;
    logic [APB_DATA-1:0]   prdata;
    logic                  pready;

    ps2ct_byte_if   in_if();
    ps2ct_cursor_if out_if();

    ps2_mouse_packet_cursor_tracker uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (in_if),
        .out_cursor (out_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    cursor_predictor sb = new();

    // set for a phase to drop all idling on both sides
    bit steady = 1'b0;
    int cursors_seen = 0;
    int cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Gap length: mostly none, often a few cycles, now and then a long one.
    function automatic int gap_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: checks each accepted word, then picks ready for the next edge.
    // Once, after a few dozen words, it holds off long enough to back the
    // block up into its input while the sender keeps offering.
    initial
    begin
        int  rx_hold;
        int  g;
        bit  held_off;
        rx_hold  = 0;
        held_off = 1'b0;
        out_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_if.valid && out_if.ready)
            begin
                sb.check_cursor(out_if.cursor_x, out_if.cursor_y, out_if.left_down);
                cursors_seen++;
            end
            if (!held_off && cursors_seen == HOLD_OFF_AT)
            begin
                held_off = 1'b1;
                rx_hold  = HOLD_OFF_CYCLES;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_if.ready <= 1'b0;
            end
            else
            begin
                g = gap_len();
                if (g > 0)
                begin
                    rx_hold = g - 1;
                    out_if.ready <= 1'b0;
                end
                else
                    out_if.ready <= 1'b1;
            end
        end
    end

    // One input word; returns at the edge where it was taken.
    task automatic send_byte(input logic fm, input logic [BYTE_BITS-1:0] b);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.from_mouse <= fm;
        in_if.rx_byte    <= b;
        do
            @(posedge clk);
        while (!in_if.ready);
        sb.take_byte(fm, b);
    endtask

    task automatic send_packet(input logic [7:0] head, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_byte(1'b1, head);
        send_byte(1'b1, dx);
        send_byte(1'b1, dy);
    endtask

    // Delta byte steered by bias: 0 any, 1 towards high x and high y,
    // 2 towards zero on both axes. Screen y grows when the mouse dy is negative.
    function automatic logic [7:0] pick_delta(int bias, bit y_axis);
        if (bias == 1)
            return y_axis ? 8'($urandom_range(8'h80, 8'hC0))
                          : 8'($urandom_range(8'h40, 8'h7F));
        if (bias == 2)
            return y_axis ? 8'($urandom_range(8'h40, 8'h7F))
                          : 8'($urandom_range(8'h80, 8'hC0));
        return 8'($urandom);
    endfunction

    // Mostly well-formed packets with random content, some with a stray
    // non-mouse word wedged in; the rest is noise and headers missing sync.
    // Only mouse words count towards n.
    task automatic random_bytes(input int n, input int bias);
        int         sent;
        int         r;
        int         slot;
        logic       fm;
        logic [7:0] pk [3];
        sent = 0;
        while (sent < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                pk[0] = 8'($urandom) | (8'h01 << SYNC_IDX);
                pk[1] = pick_delta(bias, 1'b0);
                pk[2] = pick_delta(bias, 1'b1);
                slot  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : 3;
                for (int i = 0; i < 3; i++)
                begin
                    if (i == slot)
                        send_byte(1'b0, 8'($urandom));
                    send_byte(1'b1, pk[i]);
                end
                sent += 3;
            end
            else if (r < 90)
            begin
                fm = 1'($urandom_range(0, 1));
                send_byte(fm, 8'($urandom));
                sent += fm;
            end
            else
            begin
                send_byte(1'b1, 8'($urandom) & ~(8'h01 << SYNC_IDX));
                sent++;
            end
        end
    endtask

    // Drop valid and wait for every expected word, then let a trailing
    // header or delta byte clear the block.
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write then read-back of one limit register, then psel is dropped.
    task automatic program_limit(input reg_idx_t idx, input logic [LIMIT_BITS-1:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.compare("limit read-back", val, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_limit(idx, val);
        @(posedge clk);
    endtask

    initial
    begin
        int                    k;
        logic [LIMIT_BITS-1:0] xl;
        logic [LIMIT_BITS-1:0] yl;

        rst_n            <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.from_mouse <= 1'b0;
        in_if.rx_byte    <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset limits 799/599, cursor at 400,300
        send_byte(1'b0, 8'hFF);              // not mouse data, ignored
        send_byte(1'b1, 8'hF7);              // header without sync, dropped
        send_packet(8'h09, 8'h7F, 8'h80);    // left down, +127 x, -(-128) y
        send_packet(8'h08, 8'h80, 8'h7F);    // -128 x, -127 y
        send_byte(1'b1, 8'hFF);              // header with every bit set
        send_byte(1'b0, 8'h00);              // stray word mid-packet
        send_byte(1'b1, 8'h00);
        send_byte(1'b1, 8'h00);

        // widest limits, drive the cursor towards high x and high y
        wait_idle();
        program_limit(REG_X_LIMIT, 12'd4095);
        program_limit(REG_Y_LIMIT, 12'd4095);
        random_bytes(300, 1);

        // limits lowered under the cursor: clamped on the next packet
        wait_idle();
        program_limit(REG_X_LIMIT, 12'd100);
        program_limit(REG_Y_LIMIT, 12'd50);
        send_packet(8'h08, 8'h00, 8'h00);
        random_bytes(200, 0);

        // smallest nonzero limits
        wait_idle();
        program_limit(REG_X_LIMIT, 12'd1);
        program_limit(REG_Y_LIMIT, 12'd1);
        random_bytes(100, 0);

        // zero limits pin both axes to 0
        wait_idle();
        program_limit(REG_X_LIMIT, 12'd0);
        program_limit(REG_Y_LIMIT, 12'd0);
        send_packet(8'h08, 8'h10, 8'hF0);

        // random limits; one phase with no idling at all
        for (k = 0; k < 4; k++)
        begin
            wait_idle();
            xl = 12'($urandom_range(1, 4095));
            yl = 12'($urandom_range(1, 4095));
            program_limit(REG_X_LIMIT, xl);
            program_limit(REG_Y_LIMIT, yl);
            steady = (k == 1);
            random_bytes(200, k % 3);
        end
        steady = 1'b0;

        // back to full range, drift down to the zero edges
        wait_idle();
        program_limit(REG_X_LIMIT, 12'd4095);
        program_limit(REG_Y_LIMIT, 12'd4095);
        random_bytes(150, 2);

        wait_idle();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
